// ----- rtl/tsfu_pkg.sv -----
package tsfu_pkg;

  localparam int unsigned MAX_TERMS_DEF = 1000;

  localparam int QF   = 32;
  localparam int VW   = 40;
  localparam int MW   = 39;
  localparam int ACCW = 48;
  localparam int DIVW = 40;
  localparam int IN_TDW  = 40;
  localparam int OUT_TDW = 96;

  localparam logic [MW-1:0] TMAX  = '1;
  localparam logic [MW-1:0] ONE_Q = 39'h01_0000_0000;

  localparam logic [MW-1:0] EPS_RESET = 39'd4295;

  localparam logic [2:0] KIND_EXP  = 3'd0;
  localparam logic [2:0] KIND_SIN  = 3'd1;
  localparam logic [2:0] KIND_COS  = 3'd2;
  localparam logic [2:0] KIND_LN   = 3'd3;
  localparam logic [2:0] KIND_ATAN = 3'd4;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic CFG_EPSILON = 1'b0;
  localparam logic CFG_OFFSET  = 1'b1;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_IDLE,
    UOP_INIT,
    UOP_FIRST,
    UOP_ACC,
    UOP_KSET,
    UOP_MUL0,
    UOP_MUL1,
    UOP_MUL2,
    UOP_MUL3,
    UOP_DIV_LOAD,
    UOP_DIV_STEP,
    UOP_QUOT,
    UOP_OUT,
    UOP_OUT_BAD
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_BAD_KIND,
    C_ONE_MUL,
    C_DONE,
    C_DIV_MORE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic {
    MSRC_TERM,
    MSRC_PROD
  } msrc_t;

  localparam int SW = 5;
  typedef logic [SW-1:0] step_t;

  localparam step_t S_IDLE  = 5'd0;
  localparam step_t S_INIT  = 5'd1;
  localparam step_t S_FIRST = 5'd2;
  localparam step_t S_ACC   = 5'd3;
  localparam step_t S_CHECK = 5'd4;
  localparam step_t S_KSET  = 5'd5;
  localparam step_t S_MA0   = 5'd6;
  localparam step_t S_MA1   = 5'd7;
  localparam step_t S_MA2   = 5'd8;
  localparam step_t S_MA3   = 5'd9;
  localparam step_t S_MB0   = 5'd10;
  localparam step_t S_MB1   = 5'd11;
  localparam step_t S_MB2   = 5'd12;
  localparam step_t S_MB3   = 5'd13;
  localparam step_t S_DLOAD = 5'd14;
  localparam step_t S_DSTEP = 5'd15;
  localparam step_t S_QUOT  = 5'd16;
  localparam step_t S_OUT   = 5'd17;
  localparam step_t S_OUTW  = 5'd18;
  localparam step_t S_BAD   = 5'd19;
  localparam step_t S_BADW  = 5'd20;

  typedef struct packed {
    uop_t  op;
    msrc_t msrc;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad_kind;
    logic one_mul;
    logic done;
    logic div_more;
    logic out_free;
  } flags_t;

  // microprogram: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(step_t a);
    ctrl_t w;
    case (a)
      S_IDLE:  w = '{UOP_IDLE,     MSRC_TERM, C_NO_IN,    S_IDLE};
      S_INIT:  w = '{UOP_INIT,     MSRC_TERM, C_BAD_KIND, S_BAD};
      S_FIRST: w = '{UOP_FIRST,    MSRC_TERM, C_NEVER,    S_IDLE};
      S_ACC:   w = '{UOP_ACC,      MSRC_TERM, C_NEVER,    S_IDLE};
      S_CHECK: w = '{UOP_NONE,     MSRC_TERM, C_DONE,     S_OUT};
      S_KSET:  w = '{UOP_KSET,     MSRC_TERM, C_NEVER,    S_IDLE};
      S_MA0:   w = '{UOP_MUL0,     MSRC_TERM, C_NEVER,    S_IDLE};
      S_MA1:   w = '{UOP_MUL1,     MSRC_TERM, C_NEVER,    S_IDLE};
      S_MA2:   w = '{UOP_MUL2,     MSRC_TERM, C_NEVER,    S_IDLE};
      S_MA3:   w = '{UOP_MUL3,     MSRC_TERM, C_ONE_MUL,  S_DLOAD};
      S_MB0:   w = '{UOP_MUL0,     MSRC_PROD, C_NEVER,    S_IDLE};
      S_MB1:   w = '{UOP_MUL1,     MSRC_PROD, C_NEVER,    S_IDLE};
      S_MB2:   w = '{UOP_MUL2,     MSRC_PROD, C_NEVER,    S_IDLE};
      S_MB3:   w = '{UOP_MUL3,     MSRC_PROD, C_NEVER,    S_IDLE};
      S_DLOAD: w = '{UOP_DIV_LOAD, MSRC_TERM, C_NEVER,    S_IDLE};
      S_DSTEP: w = '{UOP_DIV_STEP, MSRC_TERM, C_DIV_MORE, S_DSTEP};
      S_QUOT:  w = '{UOP_QUOT,     MSRC_TERM, C_ALWAYS,   S_ACC};
      S_OUT:   w = '{UOP_OUT,      MSRC_TERM, C_OUT_FREE, S_IDLE};
      S_OUTW:  w = '{UOP_NONE,     MSRC_TERM, C_ALWAYS,   S_OUT};
      S_BAD:   w = '{UOP_OUT_BAD,  MSRC_TERM, C_OUT_FREE, S_IDLE};
      S_BADW:  w = '{UOP_NONE,     MSRC_TERM, C_ALWAYS,   S_BAD};
      default: w = '{UOP_NONE,     MSRC_TERM, C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tsfu_seq.sv -----
module tsfu_seq (
  input  logic             clk,
  input  logic             rst,
  input  tsfu_pkg::flags_t flags,
  output tsfu_pkg::ctrl_t  cw
);
  import tsfu_pkg::*;

  step_t step;
  step_t step_next;
  logic  jump;

  always_comb begin
    cw = ucode(step);
    case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !flags.in_valid;
      C_BAD_KIND: jump = flags.bad_kind;
      C_ONE_MUL:  jump = flags.one_mul;
      C_DONE:     jump = flags.done;
      C_DIV_MORE: jump = flags.div_more;
      C_OUT_FREE: jump = flags.out_free;
      default:    jump = 1'b0;
    endcase
    step_next = jump ? cw.target : step_t'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/tsfu_div.sv -----
module tsfu_div #(
  parameter int KW = 22
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      step,
  input  logic [tsfu_pkg::DIVW-1:0] dividend,
  input  logic [KW-1:0]             divisor,
  output logic [tsfu_pkg::DIVW-1:0] quot,
  output logic                      more
);
  import tsfu_pkg::*;

  localparam int CNTW = $clog2(DIVW + 1);

  logic [KW-1:0]   rem;
  logic [KW-1:0]   dvs;
  logic [DIVW-1:0] q;
  logic [CNTW-1:0] cnt;
  logic [KW:0]     rsh;
  logic [KW:0]     rdiff;
  logic            qbit;

  // restoring radix-2, one quotient bit a cycle while step is high; dividend shifts out as quotient shifts in
  always_comb begin
    rsh   = {rem, q[DIVW-1]};
    rdiff = rsh - {1'b0, dvs};
    qbit  = (rsh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvs <= divisor;
      q   <= dividend;
    end else if (step) begin
      rem <= qbit ? rdiff[KW-1:0] : rsh[KW-1:0];
      q   <= {q[DIVW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNTW'(DIVW);
    end else if (step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign quot = q;
  assign more = (cnt != CNTW'(1));

endmodule

// ----- rtl/tsfu_dp.sv -----
module tsfu_dp #(
  parameter int unsigned MAX_TERMS = tsfu_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tsfu_pkg::ctrl_t              cw,
  output tsfu_pkg::flags_t             flags,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [tsfu_pkg::VW-1:0]      cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [2:0]                   s_tuser,
  input  logic [tsfu_pkg::IN_TDW-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tsfu_pkg::OUT_TDW-1:0] m_tdata
);
  import tsfu_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int KW = 2 * CW + 2;
  localparam int TW = (CW > 10) ? CW : 10;

  localparam logic signed [41:0] SUM_HI = 42'sd549755813887;
  localparam logic signed [41:0] SUM_LO = -42'sd549755813888;
  localparam logic signed [40:0] D_HI   = 41'sd549755813887;
  localparam logic signed [40:0] D_LO   = -41'sd549755813887;

  logic [MW-1:0]   epsilon;
  logic [VW-1:0]   offset;
  logic [2:0]      kind;
  logic [VW-1:0]   arg;
  logic [MW-1:0]   ad;
  logic            dneg;
  logic [MW-1:0]   mag;
  logic [MW-1:0]   pw;
  logic [MW-1:0]   prod;
  logic            neg;
  logic [VW-1:0]   sum;
  logic [CW-1:0]   n;
  logic [CW-1:0]   count;
  logic            sat;
  logic [ACCW-1:0] acc;
  logic [KW-1:0]   k;

  logic              accept;
  logic              out_free;
  logic              pw_kind;
  logic              one_kind;
  logic signed [40:0] d41;
  logic [40:0]       dab;
  logic              d_over;
  logic [MW-1:0]     ad_i;
  logic signed [41:0] sum_w;
  logic [CW:0]       twon;
  logic [CW:0]       ka;
  logic [CW:0]       kb;
  logic [KW-1:0]     kprod;
  logic [KW-1:0]     k_i;
  logic [MW-1:0]     ma;
  logic [31:0]       mx;
  logic [31:0]       my;
  logic [63:0]       p;
  logic [ACCW-1:0]   p_hi;
  logic [ACCW-1:0]   r;
  logic [DIVW-1:0]   dividend;
  logic [DIVW-1:0]   quot;
  logic              div_more;
  logic [TW-1:0]     cnt_w;
  logic [9:0]        terms;
  logic [1:0]        status;

  assign s_tready = (cw.op == UOP_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pw_kind  = (kind == KIND_LN) || (kind == KIND_ATAN);
  assign one_kind = (kind == KIND_EXP) || (kind == KIND_COS);

  assign flags.in_valid = s_tvalid;
  assign flags.bad_kind = (kind > KIND_ATAN);
  assign flags.one_mul  = (kind == KIND_EXP) || (kind == KIND_LN);
  assign flags.done     = (mag <= epsilon) || (count >= CW'(MAX_TERMS));
  assign flags.div_more = div_more;
  assign flags.out_free = out_free;

  // d = x - offset, clamped to the symmetric magnitude range
  always_comb begin
    d41    = $signed({arg[VW-1], arg}) - $signed({offset[VW-1], offset});
    dab    = d41[40] ? 41'(-d41) : 41'(d41);
    d_over = (d41 > D_HI) || (d41 < D_LO);
    ad_i   = d_over ? TMAX : dab[MW-1:0];
  end

  always_comb begin
    sum_w = $signed({{2{sum[VW-1]}}, sum}) +
            (neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag}));
  end

  // series divisor for term n
  always_comb begin
    twon = {n, 1'b0};
    ka   = (kind == KIND_SIN) ? twon : (CW + 1)'(twon - 1'b1);
    kb   = (kind == KIND_SIN) ? (CW + 1)'(twon + 1'b1) : twon;
    case (kind)
      KIND_SIN, KIND_COS: k_i = kprod;
      KIND_ATAN:          k_i = KW'(twon + 1'b1);
      default:            k_i = KW'(n);
    endcase
  end

  assign kprod = KW'(ka) * KW'(kb);

  // Q7.32 product over four passes of one 32x32 multiplier
  always_comb begin
    ma = (cw.msrc == MSRC_PROD) ? prod : (pw_kind ? pw : mag);
    case (cw.op)
      UOP_MUL1: begin
        mx = 32'(ma[MW-1:QF]);
        my = ad[QF-1:0];
      end
      UOP_MUL2: begin
        mx = ma[QF-1:0];
        my = 32'(ad[MW-1:QF]);
      end
      UOP_MUL3: begin
        mx = 32'(ma[MW-1:QF]);
        my = 32'(ad[MW-1:QF]);
      end
      default: begin
        mx = ma[QF-1:0];
        my = ad[QF-1:0];
      end
    endcase
    p    = 64'(mx) * 64'(my);
    p_hi = {p[ACCW-QF-1:0], {QF{1'b0}}};
    r    = acc + p_hi;
  end

  assign dividend = DIVW'(prod) + DIVW'(k[KW-1:1]);

  tsfu_div #(
    .KW(KW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cw.op == UOP_DIV_LOAD),
    .step     (cw.op == UOP_DIV_STEP),
    .dividend (dividend),
    .divisor  (k),
    .quot     (quot),
    .more     (div_more)
  );

  always_comb begin
    cnt_w  = TW'(count);
    terms  = (cnt_w > TW'(1023)) ? 10'd1023 : cnt_w[9:0];
    status = sat ? ST_SAT : ((mag <= epsilon) ? ST_CONV : ST_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
      offset  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EPSILON: epsilon <= cfg_data[MW-1:0];
        CFG_OFFSET:  offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= s_tuser;
      arg  <= s_tdata;
    end
    case (cw.op)
      UOP_INIT: begin
        ad    <= ad_i;
        dneg  <= d41[40];
        sat   <= d_over;
        sum   <= '0;
        count <= '0;
        n     <= (kind == KIND_LN) ? CW'(1) : '0;
      end
      UOP_FIRST: begin
        mag <= one_kind ? ONE_Q : ad;
        pw  <= ad;
        neg <= one_kind ? 1'b0 : dneg;
      end
      UOP_ACC: begin
        if (sum_w > SUM_HI) begin
          sum <= {1'b0, TMAX};
          sat <= 1'b1;
        end else if (sum_w < SUM_LO) begin
          sum <= {1'b1, {MW{1'b0}}};
          sat <= 1'b1;
        end else begin
          sum <= sum_w[VW-1:0];
        end
        count <= count + 1'b1;
        n     <= n + 1'b1;
      end
      UOP_KSET: k <= k_i;
      UOP_MUL0: acc <= ACCW'((p + 64'h8000_0000) >> QF);
      UOP_MUL1, UOP_MUL2: acc <= acc + ACCW'(p);
      UOP_MUL3: begin
        if (r > ACCW'(TMAX)) begin
          prod <= TMAX;
          sat  <= 1'b1;
        end else begin
          prod <= r[MW-1:0];
        end
      end
      UOP_QUOT: begin
        mag <= quot[MW-1:0];
        if (pw_kind) begin
          pw <= prod;
        end
        case (kind)
          KIND_EXP:  neg <= neg ^ dneg;
          KIND_LN:   neg <= (dneg & n[0]) ^ !n[0];
          KIND_ATAN: neg <= dneg ^ n[0];
          default:   neg <= !neg;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((cw.op == UOP_OUT || cw.op == UOP_OUT_BAD) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cw.op == UOP_OUT) begin
        m_tdata <= {5'b0, status, mag, terms, sum};
      end else if (cw.op == UOP_OUT_BAD) begin
        m_tdata <= {5'b0, ST_BAD, {(OUT_TDW - 7){1'b0}}};
      end
    end
  end

endmodule

// ----- rtl/taylor_series_function_unit.sv -----
// Maclaurin series unit for e^x, sin, cos, ln(1+x) and arctan in signed Q7.32, evaluated at
// x minus the offset register and stopped at the first term no larger than epsilon or at
// MAX_TERMS terms. One word is worked on at a time under a short microprogram. Set-up and
// the first term need no product; each further term takes one product for e^x and
// ln(1+x) and two for sin, cos and arctan, each product being four passes of one shared
// 32x32 multiplier, and then the radix-2 divider scales the term by its integer divisor.
// A new word is taken once the previous result is in the output register; an invalid kind
// skips the series and answers with only the bad status.
module taylor_series_function_unit #(
  parameter int unsigned MAX_TERMS = tsfu_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [tsfu_pkg::VW-1:0]      cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [2:0]                   s_tuser,  // kind
  input  logic [tsfu_pkg::IN_TDW-1:0]  s_tdata,  // argument
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tsfu_pkg::OUT_TDW-1:0] m_tdata   // series_sum, terms_used, last_term_size, status
);
  import tsfu_pkg::*;

  ctrl_t  cw;
  flags_t flags;

  tsfu_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  tsfu_dp #(
    .MAX_TERMS(MAX_TERMS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .flags    (flags),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/tsfu_checker.sv -----
module tsfu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tsfu_pkg::OUT_TDW-1:0] m_tdata
);
  import tsfu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in progress");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[90:89] == ST_BAD |-> m_tdata[88:0] == '0)
    else $error("invalid kind result not cleared");

  a_terms_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[90:89] != ST_BAD |-> m_tdata[49:40] != '0)
    else $error("valid result with no terms");

endmodule

bind taylor_series_function_unit tsfu_checker u_tsfu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- verif/taylor_series_function_unit_checker.sv -----
module taylor_series_function_unit_checker #(
  parameter int unsigned MAX_TERMS = tsfu_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [tsfu_pkg::VW-1:0]      cfg_data,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [2:0]                   s_tuser,   // kind
  input  logic [tsfu_pkg::IN_TDW-1:0]  s_tdata,   // argument
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [tsfu_pkg::OUT_TDW-1:0] m_tdata,   // series_sum, terms_used, last_term_size, status
  output int                           mismatches,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tsfu_pkg::*;

  localparam longint VAL_TOP = longint'(TMAX);
  localparam longint VAL_BOT = -VAL_TOP - 1;
  localparam logic [9:0] TERMS_CAP = '1;

  // result word, lowest field last
  typedef struct packed {
    logic [OUT_TDW-VW-10-MW-3:0] pad;
    logic [1:0]                  status;
    logic [MW-1:0]               last_mag;
    logic [9:0]                  terms;
    logic [VW-1:0]               sum;
  } series_word_t;

  logic [MW-1:0]        eps_reg;
  logic signed [VW-1:0] off_reg;
  series_word_t         awaited_sums[$];
  series_word_t         got;
  series_word_t         want;
  int                   fails = 0;

  // Q7.32 product of two magnitudes, rounded; top bit flags saturation
  function automatic logic [MW:0] qprod(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b) + ((2*VW)'(1) << (QF - 1));
    p = p >> QF;
    if (p > (2*VW)'(TMAX))
      return {1'b1, TMAX};
    return {1'b0, p[MW-1:0]};
  endfunction

  function automatic series_word_t evaluate_series(input logic [2:0] kind,
                                                   input logic signed [VW-1:0] x,
                                                   input logic [MW-1:0] eps,
                                                   input logic signed [VW-1:0] off);
    series_word_t r;
    longint d, acc;
    longint unsigned ad, mag, pw, base, k, n, first_n, count;
    logic [MW:0] pr;
    bit sat, dneg, neg, done;
    r = '0;
    if (kind > KIND_ATAN) begin
      r.status = ST_BAD;
      return r;
    end
    sat = 1'b0;
    d = longint'(x) - longint'(off);
    if (d > VAL_TOP) begin
      d = VAL_TOP;
      sat = 1'b1;
    end else if (d < -VAL_TOP) begin
      d = -VAL_TOP;
      sat = 1'b1;
    end
    dneg = d < 0;
    ad = dneg ? -d : d;
    acc = 0;
    count = 0;
    pw = 0;
    mag = 0;
    neg = 1'b0;
    done = 1'b0;
    // ln(1+x) has no constant term, so it starts at the linear one
    first_n = (kind == KIND_LN) ? 1 : 0;
    n = first_n;
    while (!done) begin
      if (n == first_n) begin
        pw = ad;
        if (kind == KIND_EXP || kind == KIND_COS) begin
          mag = ONE_Q;
          neg = 1'b0;
        end else begin
          mag = ad;
          neg = dneg;
        end
      end else begin
        base = (kind == KIND_LN || kind == KIND_ATAN) ? pw : mag;
        pr = qprod(base[MW-1:0], ad[MW-1:0]);
        sat |= pr[MW];
        if (kind != KIND_EXP && kind != KIND_LN) begin
          pr = qprod(pr[MW-1:0], ad[MW-1:0]);
          sat |= pr[MW];
        end
        case (kind)
          KIND_EXP: begin
            k = n;
            neg = neg ^ dneg;
          end
          KIND_SIN: begin
            k = (2 * n) * (2 * n + 1);
            neg = !neg;
          end
          KIND_COS: begin
            k = (2 * n - 1) * (2 * n);
            neg = !neg;
          end
          KIND_LN: begin
            k = n;
            neg = n[0] ? dneg : 1'b1;
          end
          default: begin
            k = 2 * n + 1;
            neg = dneg ^ n[0];
          end
        endcase
        pw = pr[MW-1:0];
        mag = (pw + (k >> 1)) / k;
      end
      acc = neg ? acc - longint'(mag) : acc + longint'(mag);
      if (acc > VAL_TOP) begin
        acc = VAL_TOP;
        sat = 1'b1;
      end else if (acc < VAL_BOT) begin
        acc = VAL_BOT;
        sat = 1'b1;
      end
      count++;
      done = (mag <= eps) || (count >= MAX_TERMS);
      n++;
    end
    r.sum = acc[VW-1:0];
    r.terms = (count > TERMS_CAP) ? TERMS_CAP : count[9:0];
    r.last_mag = mag[MW-1:0];
    r.status = sat ? ST_SAT : ((mag <= eps) ? ST_CONV : ST_LIMIT);
    return r;
  endfunction

  task automatic flag_field(input string what, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
    fails++;
    if (fails <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      eps_reg = EPS_RESET;
      off_reg = '0;
      awaited_sums.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_EPSILON)
          eps_reg = cfg_data[MW-1:0];
        else if (cfg_addr == CFG_OFFSET)
          off_reg = cfg_data;
      end
      if (s_tvalid && s_tready)
        awaited_sums.push_back(evaluate_series(s_tuser, s_tdata, eps_reg, off_reg));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (awaited_sums.size() == 0) begin
          flag_field("unexpected word, sum", '0, 64'(got.sum));
        end else begin
          want = awaited_sums.pop_front();
          if (got.sum !== want.sum)
            flag_field("series_sum", 64'(want.sum), 64'(got.sum));
          if (got.terms !== want.terms)
            flag_field("terms_used", 64'(want.terms), 64'(got.terms));
          if (got.last_mag !== want.last_mag)
            flag_field("last_term_size", 64'(want.last_mag), 64'(got.last_mag));
          if (got.status !== want.status)
            flag_field("status", 64'(want.status), 64'(got.status));
        end
      end
    end
    pending <= awaited_sums.size();
    mismatches <= fails;
  end

endmodule

// ----- verif/taylor_series_function_unit_tb.sv -----
module taylor_series_function_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsfu_pkg::*;

  localparam longint ARG_TOP = longint'(TMAX);
  localparam longint ARG_BOT = -ARG_TOP - 1;
  localparam longint QONE = longint'(ONE_Q);
  localparam logic [MW-1:0] EPS_AT_LIMIT = MW'((QONE + MAX_TERMS_DEF / 2) / MAX_TERMS_DEF);
  localparam logic [2:0] KIND_MAX_CODE = '1;
  localparam int RANDOM_WORDS = 1550;
  localparam int PHASES = 6;
  localparam int QUIET_LIMIT = 250000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_addr;
  logic [VW-1:0]      cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [2:0]         s_tuser;   // kind
  logic [IN_TDW-1:0]  s_tdata;   // argument
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_TDW-1:0] m_tdata;   // series_sum, terms_used, last_term_size, status
  int                 mismatches;
  int                 pending;

  longint cur_offset;
  bit     src_burst;

  taylor_series_function_unit uut (.*);

  taylor_series_function_unit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // signed value with magnitude below 2^width
  function automatic longint spread(input int width);
    longint m;
    m = longint'({$urandom, $urandom}) & ((64'sd1 <<< width) - 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic push_word(input logic [2:0] k, input longint x);
    int gap;
    if ($urandom_range(0, 63) == 0)
      src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= x[VW-1:0];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [MW-1:0] e, input longint o);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_EPSILON;
    cfg_data <= VW'(e);
    @(negedge clk);
    cfg_addr <= CFG_OFFSET;
    cfg_data <= o[VW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_offset = o;
  endtask

  initial begin : sink
    int gap;
    bit burst;
    m_tready = 1'b0;
    burst = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0)
        burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [2:0]    k;
    logic [MW-1:0] eps_v;
    longint        off_v, delta, x;
    int            wide;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = CFG_EPSILON;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tuser = KIND_EXP;
    s_tdata = '0;
    src_burst = 1'b0;
    cur_offset = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings
    push_word(KIND_EXP, 0);
    push_word(KIND_EXP, QONE);
    push_word(KIND_EXP, -QONE);
    push_word(KIND_EXP, 5 * QONE);       // sum clamps
    push_word(KIND_SIN, QONE / 2);
    push_word(KIND_COS, QONE);
    push_word(KIND_LN, QONE / 2);
    push_word(KIND_LN, -QONE / 2);
    push_word(KIND_ATAN, QONE / 2);
    push_word(KIND_ATAN, -(3 * QONE / 4));
    push_word(3'(KIND_ATAN + 3'd1), ARG_TOP);
    push_word(3'(KIND_ATAN + 3'd2), ARG_BOT);
    push_word(KIND_MAX_CODE, -QONE);
    push_word(KIND_EXP, ARG_TOP);        // products saturate
    push_word(KIND_SIN, ARG_BOT);        // d clamped
    push_word(KIND_ATAN, 2 * QONE);      // diverges to term limit
    push_word(KIND_LN, QONE);            // term limit, not converged
    settle();

    // last allowed term lands exactly on epsilon
    set_regs(EPS_AT_LIMIT, 0);
    push_word(KIND_LN, QONE);
    settle();

    set_regs('0, 0);
    push_word(KIND_EXP, QONE / 2);
    push_word(KIND_SIN, QONE);
    settle();

    set_regs(TMAX, 0);
    push_word(KIND_COS, QONE);
    push_word(KIND_EXP, -3 * QONE);
    settle();

    set_regs(EPS_RESET, ARG_TOP);
    push_word(KIND_EXP, ARG_TOP);
    push_word(KIND_COS, ARG_BOT);        // difference overflows, clamped
    settle();

    set_regs(EPS_RESET, ARG_BOT);
    push_word(KIND_EXP, ARG_BOT + QONE);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: eps_v = EPS_RESET;
        1: eps_v = '0;
        2: eps_v = MW'($urandom_range(0, 1 << 24));
        3: eps_v = TMAX;
        4: eps_v = MW'({$urandom, $urandom});
        default: eps_v = MW'($urandom_range(1, 1 << 16));
      endcase
      if (ph == 0)
        off_v = 0;
      else
        off_v = $urandom_range(0, 1) ? spread(34) : spread(39);
      set_regs(eps_v, off_v);
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          k = 3'($urandom_range(int'(KIND_ATAN) + 1, int'(KIND_MAX_CODE)));
          x = spread(39);
        end else if ($urandom_range(0, 199) == 0) begin
          k = 3'($urandom_range(int'(KIND_EXP), int'(KIND_COS)));
          x = spread(39);
        end else begin
          k = 3'($urandom_range(int'(KIND_EXP), int'(KIND_ATAN)));
          if (k == KIND_LN || k == KIND_ATAN)
            wide = 31;
          else
            wide = ($urandom_range(0, 31) == 0) ? 36 : 33;
          delta = spread($urandom_range(20, wide));
          x = cur_offset + delta;
          if (x > ARG_TOP || x < ARG_BOT)
            x = cur_offset - delta;
        end
        push_word(k, x);
      end
      settle();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tsfu_pkg.sv
rtl/tsfu_seq.sv
rtl/tsfu_div.sv
rtl/tsfu_dp.sv
rtl/taylor_series_function_unit.sv
rtl/tsfu_checker.sv
verif/taylor_series_function_unit_checker.sv
verif/taylor_series_function_unit_tb.sv
